FILE: src/periodic_tick_dispatch_table_defines.svh
// assertion macros for the periodic tick dispatch table
// no dependencies
`ifndef PERIODIC_TICK_DISPATCH_TABLE_DEFINES_SVH
`define PERIODIC_TICK_DISPATCH_TABLE_DEFINES_SVH

`define PTD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define PTD_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: src/ptd_pkg.sv
// shared types and constants of the periodic tick dispatch table
// no dependencies
package ptd_pkg;

    localparam int SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] interval;
        logic [31:0] offset;
        logic        enable_bit;
        logic        run_once;
        logic [3:0]  slot;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [3:0] slot_id;
        logic [1:0] status;
        logic       last;
    } t_out;

endpackage

FILE: src/ptd_if.sv
// valid/ready channel interface carrying a generic payload
// depends on nothing; payload type given by the instantiating code
interface ptd_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/periodic_tick_dispatch_table.sv
// Periodic tick dispatch table, top level.
// Depends on ptd_pkg, ptd_if, ptd_queue, ptd_back and the defines header.
//
// Channels: i_req (sink) carries one command: tick, insert, remove or clear.
// o_rsp (source) carries results; the last result of a command has last set.
// A tick yields one fire result per matching enabled slot, in slot order,
// then a done result; the other commands yield one status result.
// Commands enter a two-entry queue; the back part runs them one at a time.
// A tick visits the slots in order; for each valid enabled slot the serial
// 64-by-32 remainder unit (one bit a cycle) computes the tick count modulo
// the interval, and a remainder equal to the offset gives a fire result.
// Reset: tick count zero, all slots free, queue and output empty.
// A stalled receiver holds the current result in the output register; the
// back part waits and the queue keeps taking commands until it is full.
module periodic_tick_dispatch_table #(
    parameter int SLOTS = ptd_pkg::SLOTS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    ptd_if.sink   i_req,
    ptd_if.source o_rsp
);
    import ptd_pkg::*;
    `include "periodic_tick_dispatch_table_defines.svh"

    logic w_full, w_empty, w_pop, w_push;
    t_in  w_item;

    assign w_push      = i_req.valid && !w_full;
    assign i_req.ready = !w_full;

    ptd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_push),
        .i_wdata (i_req.data),
        .o_full  (w_full),
        .i_rd    (w_pop),
        .o_rdata (w_item),
        .o_empty (w_empty)
    );

    ptd_back #(.SLOTS(SLOTS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_item),
        .o_pop   (w_pop),
        .o_valid (o_rsp.valid),
        .o_data  (o_rsp.data),
        .i_ready (o_rsp.ready)
    );

    `PTD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_empty)
    `PTD_ASSERT_IMP(a_fire_not_last, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.data.kind == KIND_FIRE, !o_rsp.data.last)
    `PTD_ASSERT_NXT(a_full_blocks, i_clk, i_rst_n, w_full && !w_pop, !i_req.ready)
endmodule

FILE: src/ptd_queue.sv
// two-entry queue between the front and the back part
// depends on ptd_pkg
module ptd_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  ptd_pkg::t_in i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output ptd_pkg::t_in o_rdata,
    output logic         o_empty
);
    import ptd_pkg::*;

    t_in        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end
endmodule

FILE: src/ptd_mod.sv
// serial remainder unit: 64-bit dividend by 32-bit divisor, one bit a cycle
// depends on nothing
module ptd_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [63:0] r_dvd;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic [32:0] w_sub;

    assign w_sh  = {r_rem[31:0], r_dvd[63]};
    assign w_sub = w_sh - {1'b0, i_divisor};
    assign o_rem = r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == 7'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_rem <= w_sub[32] ? w_sh : w_sub;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule

FILE: src/ptd_back.sv
// back part: slot table, tick counter and result sequencer
// depends on ptd_pkg and ptd_mod
module ptd_back #(
    parameter int SLOTS = ptd_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  ptd_pkg::t_in  i_item,
    output logic          o_pop,
    output logic          o_valid,
    output ptd_pkg::t_out o_data,
    input  logic          i_ready
);
    import ptd_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_WAIT, S_EMIT, S_DONE
    } t_state;

    t_state      r_state;
    logic [63:0] r_tick;
    logic [SLOTS-1:0] r_valid, r_en, r_once;
    logic [31:0] r_ival [SLOTS];
    logic [31:0] r_ofs [SLOTS];
    logic [SW-1:0] r_idx;
    logic [31:0] r_cur_ofs;
    logic [31:0] r_cur_ival;
    logic        r_mstart;
    logic        w_mdone;
    logic [31:0] w_rem;
    t_out        r_out;
    logic        r_ovalid;
    logic        w_free_hit;
    logic [SW-1:0] w_free_idx;
    logic        w_last_slot;
    logic        w_rm_ok;
    logic [SW-1:0] w_rm_idx;
    logic        w_out_load;
    t_out        w_ins_out;

    ptd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mstart),
        .i_dividend (r_tick),
        .i_divisor  (r_cur_ival),
        .o_done     (w_mdone),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_free_hit = 1'b0;
        w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_hit = 1'b1;
                w_free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        w_ins_out = '{KIND_DONE, 4'd0, ST_OK, 1'b1};
        if (i_item.interval == 32'd0) begin
            w_ins_out.status = ST_ZERO;
        end else if (!w_free_hit) begin
            w_ins_out.status = ST_FULL;
        end else begin
            w_ins_out.slot_id = 4'(w_free_idx);
        end
    end

    assign w_last_slot = (32'(r_idx) == 32'(SLOTS - 1));
    assign w_rm_idx    = SW'(i_item.slot);
    assign w_rm_ok     = (32'(i_item.slot) < 32'(SLOTS)) && r_valid[w_rm_idx];
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_pop       = (r_state == S_IDLE) && !i_empty && !r_ovalid;
    assign w_out_load  = (o_pop && (t_mode'(i_item.mode) != MODE_TICK)) ||
                         (((r_state == S_EMIT) || (r_state == S_DONE)) &&
                          (!r_ovalid || i_ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_valid  <= '0;
            r_en     <= '0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_mstart <= (r_state == S_LOOK) && r_valid[r_idx] && r_en[r_idx];
            r_ovalid <= w_out_load || (r_ovalid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (t_mode'(i_item.mode))
                            MODE_TICK: begin
                                r_idx   <= '0;
                                r_state <= S_LOOK;
                            end
                            MODE_INSERT: begin
                                r_out <= w_ins_out;
                                if (i_item.interval != 32'd0 && w_free_hit) begin
                                    r_valid[w_free_idx] <= 1'b1;
                                    r_en[w_free_idx]    <= i_item.enable_bit;
                                    r_once[w_free_idx]  <= i_item.run_once;
                                    r_ival[w_free_idx]  <= i_item.interval;
                                    r_ofs[w_free_idx]   <= i_item.offset;
                                end
                            end
                            MODE_REMOVE: begin
                                r_out <= '{KIND_DONE, 4'd0,
                                           w_rm_ok ? ST_OK : ST_NOTFOUND, 1'b1};
                                if (w_rm_ok) begin
                                    r_valid[w_rm_idx] <= 1'b0;
                                    r_en[w_rm_idx]    <= 1'b0;
                                end
                            end
                            MODE_CLEAR: begin
                                r_out    <= '{KIND_DONE, 4'd0, ST_OK, 1'b1};
                                r_valid  <= '0;
                                r_en     <= '0;
                                r_tick   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (r_valid[r_idx] && r_en[r_idx]) begin
                        r_cur_ival <= r_ival[r_idx];
                        r_cur_ofs  <= r_ofs[r_idx];
                        r_state    <= S_WAIT;
                    end else if (w_last_slot) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_WAIT: begin
                    if (w_mdone) begin
                        if (w_rem == r_cur_ofs) begin
                            r_state <= S_EMIT;
                        end else if (w_last_slot) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + SW'(1);
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= '{KIND_FIRE, 4'(r_idx), ST_OK, 1'b0};
                        if (r_once[r_idx]) begin
                            r_en[r_idx] <= 1'b0;
                        end
                        if (w_last_slot) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + SW'(1);
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= '{KIND_DONE, 4'd0, ST_OK, 1'b1};
                        r_tick   <= r_tick + 64'd1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sim/tb_periodic_tick_dispatch_table.sv
// testbench for periodic_tick_dispatch_table: directed and random commands with a predictor
// depends on ptd_pkg, ptd_if and the block itself
// checks every result field by field against an in-order queue of predicted results
module tb_periodic_tick_dispatch_table;
    timeunit 1ns;
    timeprecision 1ps;
    import ptd_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   cycles = 0;
    int   errors = 0;

    ptd_if #(.T(t_in))  req_if ();
    ptd_if #(.T(t_out)) rsp_if ();

    periodic_tick_dispatch_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor copy of the table
    logic [63:0] ticks;
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_interval [NSLOT];
    logic [31:0] tbl_offset [NSLOT];
    logic        tbl_enable [NSLOT];
    logic        tbl_once [NSLOT];
    t_out        expected_results [$];

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_periodic_tick_dispatch_table: done, errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_out mk_result(logic kind, logic [3:0] id, t_status st, logic lst);
        t_out r;
        r.kind = kind;
        r.slot_id = id;
        r.status = st;
        r.last = lst;
        return r;
    endfunction

    function automatic void clear_table();
        ticks = '0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_enable[i] = 1'b0;
            tbl_interval[i] = '0;
            tbl_offset[i] = '0;
            tbl_once[i] = 1'b0;
        end
    endfunction

    function automatic void predict_dispatch(t_in cmd);
        int found;
        found = -1;
        case (t_mode'(cmd.mode))
            MODE_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_valid[i] && tbl_enable[i] && tbl_interval[i] != 0 &&
                        (ticks % {32'd0, tbl_interval[i]}) == {32'd0, tbl_offset[i]}) begin
                        expected_results.push_back(mk_result(KIND_FIRE, 4'(i), ST_OK, 1'b0));
                        if (tbl_once[i]) tbl_enable[i] = 1'b0;
                    end
                end
                expected_results.push_back(mk_result(KIND_DONE, 4'd0, ST_OK, 1'b1));
                ticks = ticks + 64'd1;
            end
            MODE_INSERT: begin
                if (cmd.interval == 0) begin
                    expected_results.push_back(mk_result(KIND_DONE, 4'd0, ST_ZERO, 1'b1));
                end else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (found < 0 && !tbl_valid[i]) found = i;
                    if (found < 0) begin
                        expected_results.push_back(mk_result(KIND_DONE, 4'd0, ST_FULL, 1'b1));
                    end else begin
                        tbl_valid[found] = 1'b1;
                        tbl_interval[found] = cmd.interval;
                        tbl_offset[found] = cmd.offset;
                        tbl_enable[found] = cmd.enable_bit;
                        tbl_once[found] = cmd.run_once;
                        expected_results.push_back(
                            mk_result(KIND_DONE, 4'(found), ST_OK, 1'b1));
                    end
                end
            end
            MODE_REMOVE: begin
                if (int'(cmd.slot) < NSLOT && tbl_valid[cmd.slot]) begin
                    tbl_valid[cmd.slot] = 1'b0;
                    tbl_enable[cmd.slot] = 1'b0;
                    expected_results.push_back(mk_result(KIND_DONE, 4'd0, ST_OK, 1'b1));
                end else begin
                    expected_results.push_back(
                        mk_result(KIND_DONE, 4'd0, ST_NOTFOUND, 1'b1));
                end
            end
            default: begin
                clear_table();
                expected_results.push_back(mk_result(KIND_DONE, 4'd0, ST_OK, 1'b1));
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk) begin
        t_out exp_r;
        t_out got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind %0d slot %0d status %0d last %0d",
                             got.kind, got.slot_id, got.status, got.last);
            end else begin
                exp_r = expected_results.pop_front();
                if (got.kind !== exp_r.kind || got.slot_id !== exp_r.slot_id ||
                    got.status !== exp_r.status || got.last !== exp_r.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_r.kind, exp_r.slot_id, exp_r.status, exp_r.last,
                                 got.kind, got.slot_id, got.status, got.last);
                end
            end
        end
    end

    task automatic send_cmd(t_mode mode, logic [31:0] interval, logic [31:0] offset,
                            logic en, logic once, logic [3:0] slot);
        t_in cmd;
        cmd.mode = mode;
        cmd.interval = interval;
        cmd.offset = offset;
        cmd.enable_bit = en;
        cmd.run_once = once;
        cmd.slot = slot;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= cmd;
        do @(posedge clk); while (!req_if.ready);
        predict_dispatch(cmd);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_insert_and_fire();
        send_cmd(MODE_INSERT, 32'd1, 32'd0, 1'b1, 1'b0, 4'd0);
        send_cmd(MODE_INSERT, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15);
        send_cmd(MODE_INSERT, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 4'd0);
        send_cmd(MODE_INSERT, 32'd3, 32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0);
        send_cmd(MODE_INSERT, 32'd2, 32'd1, 1'b0, 1'b0, 4'd0);
        send_cmd(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15);
        send_cmd(MODE_TICK, '0, '0, 1'b0, 1'b0, 4'd0);
        send_cmd(MODE_TICK, '0, '0, 1'b0, 1'b0, 4'd0);
        drain();
    endtask

    task automatic test_remove();
        send_cmd(MODE_REMOVE, '0, '0, 1'b0, 1'b0, 4'd1);
        send_cmd(MODE_REMOVE, '0, '0, 1'b0, 1'b0, 4'd1);
        send_cmd(MODE_REMOVE, '0, '0, 1'b0, 1'b0, 4'd15);
        send_cmd(MODE_INSERT, 32'd2, 32'd1, 1'b1, 1'b1, 4'd0);
        drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 13; i++)
            send_cmd(MODE_INSERT, 32'd2, 32'(i % 2), 1'b1, 1'b0, 4'd0);
        send_cmd(MODE_TICK, '0, '0, 1'b0, 1'b0, 4'd0);
        send_cmd(MODE_REMOVE, '0, '0, 1'b0, 1'b0, 4'd15);
        send_cmd(MODE_TICK, '0, '0, 1'b0, 1'b0, 4'd0);
        drain();
    endtask

    task automatic test_clear();
        send_cmd(MODE_CLEAR, '0, '0, 1'b0, 1'b0, 4'd0);
        send_cmd(MODE_TICK, '0, '0, 1'b0, 1'b0, 4'd0);
        send_cmd(MODE_REMOVE, '0, '0, 1'b0, 1'b0, 4'd0);
        drain();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        int pick;
        logic [31:0] ival;
        logic [31:0] oval;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            ival = $urandom;
            oval = $urandom;
            if (pick < 50) begin
                send_cmd(MODE_TICK, ival, oval, 1'($urandom), 1'($urandom), 4'($urandom));
            end else if (pick < 78) begin
                case ($urandom_range(9))
                    0: ival = '0;
                    1: ;
                    default: begin
                        ival = $urandom_range(1, 6);
                        oval = $urandom_range(0, ival);
                    end
                endcase
                send_cmd(MODE_INSERT, ival, oval, 1'($urandom_range(3) != 0), 1'($urandom),
                         4'($urandom));
            end else if (pick < 96) begin
                send_cmd(MODE_REMOVE, ival, oval, 1'($urandom), 1'($urandom),
                         4'($urandom_range(15)));
            end else begin
                send_cmd(MODE_CLEAR, ival, oval, 1'($urandom), 1'($urandom), 4'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        clear_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_insert_and_fire();
        test_remove();
        test_full_table();
        test_clear();
        test_random(20, 0, 0);
        test_random(20, 51, 0);
        test_random(20, 0, 51);
        test_random(20, 21, 21);
        repeat (1200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_periodic_tick_dispatch_table: done, clean");
        else
            $display("tb_periodic_tick_dispatch_table: done, errors");
        $finish;
    end
endmodule

FILE: periodic_tick_dispatch_table.f
+incdir+src
src/ptd_pkg.sv
src/ptd_if.sv
src/ptd_queue.sv
src/ptd_mod.sv
src/ptd_back.sv
src/periodic_tick_dispatch_table.sv
sim/tb_periodic_tick_dispatch_table.sv
